[sv/esched_pkg.sv]
// Shared types and constants of the elevator disk request scheduler.
package esched_pkg;

	localparam int ADDR_W = 32;
	localparam int CNT_W = 8;
	localparam int TAG_W = 8;
	localparam int ENTRY_W = ADDR_W + CNT_W + 1 + TAG_W;
	localparam int TDATA_W = ((ENTRY_W + 7) / 8) * 8;
	localparam int TUSER_OUT_W = 3;

	localparam logic CMD_SUBMIT = 1'b0;
	localparam logic CMD_COMPLETE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_FULL = 2'd1,
		STATUS_NO_SERVICE = 2'd2
	} status_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic wr;
		logic [CNT_W-1:0] count;
		logic [ADDR_W-1:0] addr;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} esched_cmd_t;

endpackage

[sv/esched_ctrl.sv]
// Controller state machine: accepts one item, runs it, hands the result to the output register.
module esched_ctrl
	import esched_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	output logic        m_tvalid,
	input  logic        m_tready,
	output esched_cmd_t ctl
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign ctl.capture = s_tvalid && (state_q == ST_IDLE);
	assign ctl.execute = (state_q == ST_EXEC) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.execute) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (ctl.capture) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (ctl.execute) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/esched_dp.sv]
// Datapath: sorted request table, service pointer, sweep direction and result register.
module esched_dp
	import esched_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  esched_cmd_t            ctl,
	input  logic [TDATA_W-1:0]     s_tdata,
	input  logic                   s_tuser,
	output logic [TDATA_W-1:0]     m_tdata,
	output logic [TUSER_OUT_W-1:0] m_tuser
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

	logic             in_cmd_q;
	entry_t           in_ent_q;
	entry_t           ent_q [QUEUE_DEPTH];
	logic [OCC_W-1:0] occ_q;
	logic [IDX_W-1:0] sp_q;
	logic             busy_q;
	logic             dir_q;
	entry_t           out_ent_q;
	logic             out_iss_q;
	status_t          out_status_q;

	logic [QUEUE_DEPTH-1:0] le;
	logic [QUEUE_DEPTH-1:0] le_prev;
	logic             full;
	logic             no_service;
	logic             at_tail;
	logic             at_head;
	logic             dir_next;
	logic [IDX_W-1:0] nidx;
	logic             ins_en;
	logic             drop_en;
	entry_t           res_ent;
	logic             res_iss;
	status_t          res_status;

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			le[i] = (OCC_W'(i) < occ_q) && (ent_q[i].addr <= in_ent_q.addr);
		end
	end

	assign full = (occ_q == OCC_W'(QUEUE_DEPTH));
	assign no_service = !busy_q || (occ_q == '0) || (OCC_W'(sp_q) >= occ_q);
	assign at_tail = ((OCC_W'(sp_q) + OCC_W'(1)) == occ_q);
	assign at_head = (sp_q == '0);
	assign dir_next = (dir_q && at_tail) ? 1'b0 : ((!dir_q && at_head) ? 1'b1 : dir_q);
	assign nidx = dir_next ? (sp_q + IDX_W'(1)) : (sp_q - IDX_W'(1));
	assign ins_en = ctl.execute && (in_cmd_q == CMD_SUBMIT) && !full;
	assign drop_en = ctl.execute && (in_cmd_q == CMD_COMPLETE) && !no_service;

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		entry_t prev_ent;
		entry_t next_ent;
		if (g == 0) begin : g_first
			assign le_prev[g] = 1'b1;
			assign prev_ent = in_ent_q;
		end else begin : g_mid
			assign le_prev[g] = le[g-1];
			assign prev_ent = ent_q[g-1];
		end
		if (g == QUEUE_DEPTH - 1) begin : g_last
			assign next_ent = ent_q[g];
		end else begin : g_inner
			assign next_ent = ent_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (ins_en && !le[g]) begin
				ent_q[g] <= le_prev[g] ? in_ent_q : prev_ent;
			end else if (drop_en && (IDX_W'(g) >= sp_q)) begin
				ent_q[g] <= next_ent;
			end
		end
	end

	always_comb begin
		res_ent = '0;
		res_iss = 1'b0;
		res_status = STATUS_OK;
		if (in_cmd_q == CMD_SUBMIT) begin
			if (full) begin
				res_status = STATUS_FULL;
			end else if (!busy_q) begin
				res_ent = in_ent_q;
				res_iss = 1'b1;
			end
		end else if (no_service) begin
			res_status = STATUS_NO_SERVICE;
		end else if (occ_q != OCC_W'(1)) begin
			res_ent = ent_q[nidx];
			res_iss = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			in_cmd_q <= s_tuser;
			in_ent_q <= s_tdata[ENTRY_W-1:0];
		end
		if (ctl.execute) begin
			out_ent_q <= res_ent;
			out_iss_q <= res_iss;
			out_status_q <= res_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			sp_q <= '0;
			busy_q <= 1'b0;
			dir_q <= 1'b0;
		end else if (ins_en) begin
			occ_q <= occ_q + OCC_W'(1);
			if (!busy_q) begin
				busy_q <= 1'b1;
				sp_q <= '0;
			end else if (!le[sp_q]) begin
				sp_q <= sp_q + IDX_W'(1);
			end
		end else if (drop_en) begin
			dir_q <= dir_next;
			occ_q <= occ_q - OCC_W'(1);
			if (occ_q == OCC_W'(1)) begin
				busy_q <= 1'b0;
				sp_q <= '0;
			end else if (!dir_next) begin
				sp_q <= sp_q - IDX_W'(1);
			end
		end
	end

	assign m_tdata = {{(TDATA_W - ENTRY_W){1'b0}}, out_ent_q};
	assign m_tuser = {out_status_q, out_iss_q};

endmodule

[sv/elevator_disk_request_scheduler.sv]
// Top level of the elevator disk request scheduler.
// Each item is first registered, then the table is updated and the result is formed in the execute
// state; the result waits in the output register while the next item is taken in, and the execute
// state waits while a previous result is still held there. Pending requests sit in a sorted row of
// QUEUE_DEPTH register cells that shift on insert or removal, and every item gives exactly one
// result item. There is no clearing pass after reset.
module elevator_disk_request_scheduler
	import esched_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// Fields from bit 0: block_addr, sector_count, is_write, requester_tag, zero fill.
	input  logic [TDATA_W-1:0]     s_tdata,
	// Fields from bit 0: cmd.
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// Fields from bit 0: issue_addr, issue_count, issue_write, issue_tag, zero fill.
	output logic [TDATA_W-1:0]     m_tdata,
	// Fields from bit 0: issue_valid, status.
	output logic [TUSER_OUT_W-1:0] m_tuser
);

	esched_cmd_t ctl;

	esched_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.ctl      (ctl)
	);

	esched_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

[sv/esched_chk.sv]
// Port checker for the elevator disk request scheduler and its bind statement.
module esched_chk
	import esched_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [TDATA_W-1:0]     m_tdata,
	input logic [TUSER_OUT_W-1:0] m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Result item changed while stalled.");

	a_issue_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[2:1] == STATUS_OK)
		else $error("Issued request carries an error status.");

	a_no_issue_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("Payload not cleared without an issue.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Second item taken while one is still at work.");

endmodule

bind elevator_disk_request_scheduler esched_chk u_esched_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
